// ===== hw/rtl/scfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scfb_pkg;

    // Input operation codes.
    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } scfb_op_t;

    // Kind of work entry handed from the front to the back.
    typedef enum logic {
        KIND_HEADER = 1'b0,
        KIND_DATA   = 1'b1
    } scfb_kind_t;

    // Fixed frame bytes.
    localparam logic [7:0]  SOP_LO     = 8'hAA;
    localparam logic [7:0]  SOP_HI     = 8'hBB;
    localparam logic [7:0]  STUFF_MARK = 8'hAA;
    localparam logic [7:0]  STUFF_FILL = 8'h00;
    localparam logic [7:0]  ZERO_BYTE  = 8'h00;
    localparam logic [15:0] LEN_BIAS   = 16'd5;

    // Byte positions walked by the back sequencer.
    localparam int unsigned STEP_W = 4;
    typedef logic [STEP_W-1:0] scfb_step_t;

    localparam scfb_step_t STEP_SOP_LO    = 4'd0;
    localparam scfb_step_t STEP_SOP_HI    = 4'd1;
    localparam scfb_step_t STEP_LEN_LO    = 4'd2;
    localparam scfb_step_t STEP_LEN_HI    = 4'd3;
    localparam scfb_step_t STEP_ZERO_A    = 4'd4;
    localparam scfb_step_t STEP_ZERO_B    = 4'd5;
    localparam scfb_step_t STEP_CMD_LO    = 4'd6;
    localparam scfb_step_t STEP_CMD_HI    = 4'd7;
    localparam scfb_step_t STEP_HDR_CHECK = 4'd8;

    localparam scfb_step_t STEP_DATA       = 4'd0;
    localparam scfb_step_t STEP_FILL       = 4'd1;
    localparam scfb_step_t STEP_DATA_CHECK = 4'd2;

    // One classified work entry.
    typedef struct packed {
        scfb_kind_t  kind;
        logic        done;       // the frame closes with a check byte
        logic        stuffed;    // data byte needs a fill byte after it
        logic [15:0] frame_len;  // payload length plus bias, wrapped
        logic [15:0] cmd;
        logic [7:0]  data;
        logic [7:0]  check;      // check byte value if done is set
    } scfb_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scfb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scfb_queue
    import scfb_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire scfb_entry_t push_entry,
    output logic             full,
    input  wire logic        pop,
    output logic             head_valid,
    output scfb_entry_t      head_entry
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    scfb_entry_t   mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign full       = (count_reg == (AW+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // The front must hold off while the queue is full, and the back may only
    // take an entry that is there.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== hw/rtl/scfb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scfb_front
    import scfb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [15:0] cmd_code,
    input  wire logic [15:0] payload_length,
    input  wire logic [7:0]  data_byte,
    input  wire logic        queue_full,
    output logic             push,
    output scfb_entry_t      push_entry
);

    logic        frame_open_reg, frame_open_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [7:0]  check_reg, check_next;
    logic        accept;
    logic        is_start;
    logic [15:0] frame_len;
    logic [7:0]  data_check;
    logic        data_done;

    assign in_stall   = queue_full;
    assign accept     = in_valid && !queue_full;
    assign is_start   = (opcode == OP_START);
    assign frame_len  = payload_length + LEN_BIAS;
    assign data_check = check_reg ^ data_byte;
    assign data_done  = (remaining_reg <= 16'd1);

    always_comb
    begin
        frame_open_next = frame_open_reg;
        remaining_next  = remaining_reg;
        check_next      = check_reg;
        push            = 1'b0;

        push_entry.kind      = KIND_HEADER;
        push_entry.done      = 1'b0;
        push_entry.stuffed   = (data_byte == STUFF_MARK);
        push_entry.frame_len = frame_len;
        push_entry.cmd       = cmd_code;
        push_entry.data      = data_byte;
        push_entry.check     = check_reg;

        if (accept && is_start)
        begin
            push             = 1'b1;
            check_next       = frame_len[15:8] ^ cmd_code[7:0] ^ cmd_code[15:8];
            push_entry.check = check_next;
            push_entry.done  = (payload_length == 16'd0);
            frame_open_next  = (payload_length != 16'd0);
            remaining_next   = payload_length;
        end
        else if (accept && frame_open_reg)
        begin
            // A data byte with no frame open is dropped without a result.
            push             = 1'b1;
            push_entry.kind  = KIND_DATA;
            push_entry.done  = data_done;
            push_entry.check = data_check;
            check_next       = data_check;
            frame_open_next  = !data_done;
            remaining_next   = data_done ? 16'd0 : remaining_reg - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            remaining_reg  <= '0;
            check_reg      <= '0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            remaining_reg  <= remaining_next;
            check_reg      <= check_next;
        end
    end

    // A closed frame never carries a byte count into the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
                     !frame_open_reg |-> (remaining_reg == 16'd0))
        else $error("byte count left over in a closed frame");

endmodule

`default_nettype wire

// ===== hw/rtl/scfb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scfb_back
    import scfb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire scfb_entry_t head_entry,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last_of_run,
    output logic             frame_end
);

    scfb_entry_t cur_reg, cur_next;
    scfb_step_t  step_reg, step_next;
    logic        active_reg, active_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_end_reg;

    logic        load_en;
    logic        emit;
    logic [7:0]  byte_sel;
    logic        is_last;
    logic        is_end;
    scfb_step_t  step_adv;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign frame_end   = out_end_reg;

    assign load_en = !out_valid_reg || !out_stall;
    assign emit    = active_reg && load_en;
    assign pop     = head_valid && (!active_reg || (emit && is_last));

    // Byte at the current position of the current entry.
    always_comb
    begin
        byte_sel = ZERO_BYTE;
        is_last  = 1'b0;
        is_end   = 1'b0;
        step_adv = step_reg + scfb_step_t'(1);
        if (cur_reg.kind == KIND_HEADER)
        begin
            case (step_reg)
                STEP_SOP_LO:    byte_sel = SOP_LO;
                STEP_SOP_HI:    byte_sel = SOP_HI;
                STEP_LEN_LO:    byte_sel = cur_reg.frame_len[7:0];
                STEP_LEN_HI:    byte_sel = cur_reg.frame_len[15:8];
                STEP_ZERO_A:    byte_sel = ZERO_BYTE;
                STEP_ZERO_B:    byte_sel = ZERO_BYTE;
                STEP_CMD_LO:    byte_sel = cur_reg.cmd[7:0];
                STEP_CMD_HI:
                begin
                    byte_sel = cur_reg.cmd[15:8];
                    is_last  = !cur_reg.done;
                end
                STEP_HDR_CHECK:
                begin
                    byte_sel = cur_reg.check;
                    is_last  = 1'b1;
                    is_end   = 1'b1;
                end
                default:        is_last = 1'b1;
            endcase
        end
        else
        begin
            case (step_reg)
                STEP_DATA:
                begin
                    byte_sel = cur_reg.data;
                    is_last  = !cur_reg.stuffed && !cur_reg.done;
                    step_adv = cur_reg.stuffed ? STEP_FILL : STEP_DATA_CHECK;
                end
                STEP_FILL:
                begin
                    byte_sel = STUFF_FILL;
                    is_last  = !cur_reg.done;
                    step_adv = STEP_DATA_CHECK;
                end
                STEP_DATA_CHECK:
                begin
                    byte_sel = cur_reg.check;
                    is_last  = 1'b1;
                    is_end   = 1'b1;
                end
                default:        is_last = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        cur_next    = cur_reg;
        step_next   = step_reg;
        active_next = active_reg;
        if (pop)
        begin
            cur_next    = head_entry;
            step_next   = '0;
            active_next = 1'b1;
        end
        else if (emit && is_last)
        begin
            active_next = 1'b0;
        end
        else if (emit)
        begin
            step_next = step_adv;
        end
        out_valid_next = load_en ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= is_last;
            out_end_reg  <= is_end;
        end
    end

    // The check byte always closes the run of its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (out_valid_reg && out_end_reg) |-> out_last_reg)
        else $error("check byte not marked as last of run");
    // A header never walks past its check byte.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (active_reg && (cur_reg.kind == KIND_HEADER))
                     |-> (step_reg <= STEP_HDR_CHECK))
        else $error("header position out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/stuffed_command_frame_builder_core.sv =====
// Stuffed command frame builder. Each input transaction is either a start item
// (opcode 0, carrying cmd_code and payload_length) or a payload byte (opcode 1,
// carrying data_byte); the block turns them into a serial frame, one byte per
// output transaction: 0xAA 0xBB, length plus five (little endian), two zero
// bytes, the command low and high bytes, the payload with a 0x00 inserted after
// every 0xAA, and an XOR check byte flagged by frame_end. last_of_run marks the
// final byte caused by each input transaction. Payload bytes with no frame open
// produce nothing, and a start item abandons any open frame. The front end
// takes one input transaction per cycle while its queue (QUEUE_DEPTH entries)
// has room; the back end emits exactly one byte per cycle while out_stall is low
// and work is queued, so a start item yields eight bytes (nine for an empty
// payload) and a payload byte one to three, and sustained input rate is set
// by that output sequencer. When the block is idle, the first byte of a
// transaction passes through the queue, the back end's current-entry register
// and the output register before it is presented on the output.
`timescale 1ns / 1ps
`default_nettype none

module stuffed_command_frame_builder_core
    import scfb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [15:0] cmd_code,
    input  wire logic [15:0] payload_length,
    input  wire logic [7:0]  data_byte,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last_of_run,
    output logic             frame_end
);

    // Classified work travels from the front end to the back end through the
    // queue, so an output stall only reaches the input once the queue fills.
    logic        push;
    scfb_entry_t push_entry;
    logic        queue_full;
    logic        pop;
    logic        head_valid;
    scfb_entry_t head_entry;

    // The front end tracks the open frame, the remaining payload count and the
    // running check value, and decides what each transaction must produce.
    scfb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .cmd_code       (cmd_code),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .queue_full     (queue_full),
        .push           (push),
        .push_entry     (push_entry)
    );

    scfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // The back end walks each entry byte by byte into a registered output and
    // fetches the next entry on the same cycle that the last byte is loaded.
    scfb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .frame_end   (frame_end)
    );

endmodule

`default_nettype wire
